/* design/stps_pkg.sv */
package stps_pkg;

  // Coil and phase sizing
  localparam int COIL_COUNT = 4;
  localparam int PH_W       = $clog2(COIL_COUNT);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int AMOUNT_W = 32;
  localparam int RPM_W    = 8;
  localparam int SPR_W    = 16;
  localparam int EFF_W    = SPR_W + 1;
  localparam int STEP_W   = 32;
  localparam int TIME_W   = 32;

  // Stream packing
  localparam int IN_TDATA_W  = ((1 + AMOUNT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COIL_COUNT + 2 + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - COIL_COUNT - 2;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = SPR_W;
  localparam logic [CFG_ADDR_W-1:0] REG_RPM   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEPS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF  = 2'd2;

  localparam logic [RPM_W-1:0] RPM_RESET = 8'd10;
  localparam logic [SPR_W-1:0] SPR_RESET = 16'd2048;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEPS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REVS  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DEGS  = 2'd3;

  // Interval divider
  localparam int US_PER_MIN = 60000000;
  localparam int NUM_W      = $clog2(US_PER_MIN + 1);
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int DIV_W      = EFF_W + RPM_W;
  localparam logic [NUM_W-1:0] US_NUM = NUM_W'(US_PER_MIN);
  localparam logic [TIME_W-1:0] RESET_INTERVAL =
    TIME_W'(US_PER_MIN / (int'(SPR_RESET) * int'(RPM_RESET)));

  // Revolution and degree conversion; 360 = 8 * 45
  localparam int REV_W      = 8;
  localparam int DEG_W      = 16;
  localparam int REV_PROD_W = REV_W + EFF_W;
  localparam int DEG_PROD_W = DEG_W + EFF_W;
  localparam int DEG_PRE    = 3;
  localparam int DEG_DIV    = 45;
  localparam int DEG_X_W    = DEG_PROD_W - DEG_PRE;
  localparam int DEG_SHIFT  = DEG_X_W + $clog2(DEG_DIV);
  localparam logic [63:0] DEG_RECIP_64 =
    ((64'd1 << DEG_SHIFT) + 64'(DEG_DIV - 1)) / 64'(DEG_DIV);
  localparam int RECIP_W    = $clog2(DEG_RECIP_64 + 64'd1);
  localparam logic [RECIP_W-1:0] DEG_RECIP = RECIP_W'(DEG_RECIP_64);
  localparam int DEG_MUL_W  = DEG_X_W + RECIP_W;
  localparam int DEG_Q_W    = DEG_MUL_W - DEG_SHIFT;

  typedef struct packed {
    logic [EFF_W-1:0]  eff_steps;
    logic              half_step;
    logic [TIME_W-1:0] interval;
    logic              busy;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                clockwise;
    logic [AMOUNT_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic [COIL_COUNT-1:0] coils;
    logic                  stepped;
    logic                  busy_res;
  } res_t;

endpackage

/* design/stps_interval_div.sv */
module stps_interval_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [stps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [stps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output stps_pkg::cfg_t                   cfg_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_DIV  = 3'b100
  } div_state_t;

  div_state_t state_r, state_nxt;

  logic [stps_pkg::RPM_W-1:0]  rpm_r;
  logic [stps_pkg::SPR_W-1:0]  spr_r;
  logic                        half_r;
  logic [stps_pkg::EFF_W-1:0]  eff;
  logic [stps_pkg::DIV_W-1:0]  divisor_r, divisor_nxt;
  logic [stps_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [stps_pkg::NUM_W-1:0]  quo_r, quo_nxt;
  logic [stps_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [stps_pkg::TIME_W-1:0] interval_r, interval_nxt;
  logic [stps_pkg::DIV_W:0]    rem_sh;
  logic [stps_pkg::DIV_W:0]    rem_diff;
  logic                        rem_ge;
  logic                        cfg_hit;

  assign eff = half_r ? {spr_r, 1'b0} : {1'b0, spr_r};

  assign cfg_hit = cfg_we && (cfg_addr == stps_pkg::REG_RPM ||
                              cfg_addr == stps_pkg::REG_STEPS ||
                              cfg_addr == stps_pkg::REG_HALF);

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_r  <= stps_pkg::RPM_RESET;
      spr_r  <= stps_pkg::SPR_RESET;
      half_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        stps_pkg::REG_RPM:   rpm_r  <= cfg_wdata[stps_pkg::RPM_W-1:0];
        stps_pkg::REG_STEPS: spr_r  <= cfg_wdata;
        stps_pkg::REG_HALF:  half_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // One quotient bit per cycle, restoring
  assign rem_sh   = {rem_r, stps_pkg::US_NUM[cnt_r]};
  assign rem_diff = rem_sh - {1'b0, divisor_r};
  assign rem_ge   = (rem_sh >= {1'b0, divisor_r});

  always_comb begin
    state_nxt    = state_r;
    divisor_nxt  = divisor_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    interval_nxt = interval_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_hit) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        divisor_nxt = eff * rpm_r;
        rem_nxt     = '0;
        quo_nxt     = '0;
        cnt_nxt     = stps_pkg::CNT_W'(stps_pkg::NUM_W - 1);
        if (rpm_r == '0 || spr_r == '0) begin
          // zero divisor: no step can ever fire
          interval_nxt = '1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_diff[stps_pkg::DIV_W-1:0] : rem_sh[stps_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[stps_pkg::NUM_W-2:0], rem_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          interval_nxt = {{(stps_pkg::TIME_W - stps_pkg::NUM_W){1'b0}},
                          quo_r[stps_pkg::NUM_W-2:0], rem_ge};
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // restart on a fresh write
    if (cfg_hit) state_nxt = ST_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      interval_r <= stps_pkg::RESET_INTERVAL;
    end else begin
      state_r    <= state_nxt;
      interval_r <= interval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign cfg_o.eff_steps = eff;
  assign cfg_o.half_step = half_r;
  assign cfg_o.interval  = interval_r;
  assign cfg_o.busy      = (state_r != ST_IDLE) || cfg_hit;

endmodule

/* design/stps_seq_core.sv */
module stps_seq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_acc,
  input  stps_pkg::item_t     item,
  input  stps_pkg::cfg_t      cfg,
  output logic                res_valid,
  output stps_pkg::res_t      res,
  output logic                deg_pend
);

  logic [stps_pkg::STEP_W-1:0]     sr_r, sr_nxt;
  logic                            ccw_r, ccw_nxt;
  logic [stps_pkg::PH_W-1:0]       ph_r, ph_nxt;
  logic [stps_pkg::PH_W-1:0]       prev_r, prev_nxt;
  logic                            wt_r, wt_nxt;
  logic [stps_pkg::COIL_COUNT-1:0] pat_r, pat_nxt;
  logic [stps_pkg::TIME_W-1:0]     el_r, el_nxt;
  logic                            deg_pend_r, deg_pend_nxt;
  logic [stps_pkg::DEG_PROD_W-1:0] deg_prod_r, deg_prod_nxt;

  logic [stps_pkg::TIME_W-1:0]     el_inc;
  logic [stps_pkg::REV_PROD_W-1:0] rev_prod;
  logic [stps_pkg::DEG_MUL_W-1:0]  deg_mul;
  logic [stps_pkg::PH_W-1:0]       ph_fwd, ph_back, ph_new;
  logic                            fire;
  logic                            stepped;

  assign el_inc   = (el_r == '1) ? el_r : el_r + 1'b1;
  assign rev_prod = item.amount[stps_pkg::REV_W-1:0] * cfg.eff_steps;
  assign deg_prod_nxt = item.amount[stps_pkg::DEG_W-1:0] * cfg.eff_steps;
  // divide by 8 with a shift, then by 45 through the reciprocal
  assign deg_mul  = deg_prod_r[stps_pkg::DEG_PROD_W-1:stps_pkg::DEG_PRE] * stps_pkg::DEG_RECIP;

  assign ph_fwd  = (ph_r == stps_pkg::PH_W'(stps_pkg::COIL_COUNT - 1)) ? '0 : ph_r + 1'b1;
  assign ph_back = (ph_r == '0) ? stps_pkg::PH_W'(stps_pkg::COIL_COUNT - 1) : ph_r - 1'b1;
  assign ph_new  = ccw_r ? ph_back : ph_fwd;

  assign fire = item_acc && (item.kind == stps_pkg::KIND_TICK) &&
                (sr_r != '0) && (el_inc > cfg.interval);

  // Update the sequencer state for one item
  always_comb begin
    sr_nxt       = sr_r;
    ccw_nxt      = ccw_r;
    ph_nxt       = ph_r;
    prev_nxt     = prev_r;
    wt_nxt       = wt_r;
    pat_nxt      = pat_r;
    el_nxt       = el_r;
    deg_pend_nxt = 1'b0;
    stepped      = 1'b0;
    if (deg_pend_r) begin
      sr_nxt = {{(stps_pkg::STEP_W - stps_pkg::DEG_Q_W){1'b0}},
                deg_mul[stps_pkg::DEG_MUL_W-1:stps_pkg::DEG_SHIFT]};
    end else if (item_acc) begin
      case (item.kind)
        stps_pkg::KIND_TICK: begin
          el_nxt = el_inc;
          if (fire) begin
            el_nxt  = '0;
            stepped = 1'b1;
            sr_nxt  = sr_r - 1'b1;
            wt_nxt  = ~wt_r;
            if (cfg.half_step && !wt_r) begin
              // release the trailing coil
              pat_nxt[prev_r] = 1'b0;
            end else begin
              prev_nxt        = ph_r;
              ph_nxt          = ph_new;
              pat_nxt[ph_new] = 1'b1;
              pat_nxt[ph_r]   = cfg.half_step;
            end
          end
        end
        stps_pkg::KIND_STEPS: begin
          sr_nxt  = item.amount;
          ccw_nxt = ~item.clockwise;
        end
        stps_pkg::KIND_REVS: begin
          sr_nxt  = stps_pkg::STEP_W'(rev_prod);
          ccw_nxt = ~item.clockwise;
        end
        default: begin
          // degree move finishes in the next cycle
          ccw_nxt      = ~item.clockwise;
          deg_pend_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r       <= '0;
      ccw_r      <= 1'b0;
      ph_r       <= '0;
      prev_r     <= '0;
      wt_r       <= 1'b0;
      pat_r      <= '0;
      el_r       <= '0;
      deg_pend_r <= 1'b0;
    end else begin
      sr_r       <= sr_nxt;
      ccw_r      <= ccw_nxt;
      ph_r       <= ph_nxt;
      prev_r     <= prev_nxt;
      wt_r       <= wt_nxt;
      pat_r      <= pat_nxt;
      el_r       <= el_nxt;
      deg_pend_r <= deg_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deg_prod_r <= deg_prod_nxt;
  end

  assign res_valid    = deg_pend_r || (item_acc && item.kind != stps_pkg::KIND_DEGS);
  assign res.coils    = pat_nxt;
  assign res.stepped  = stepped;
  assign res.busy_res = (sr_nxt != '0);
  assign deg_pend     = deg_pend_r;

endmodule

/* design/stepper_phase_sequencer_unit.sv */
// Timing: a result is in the output register in the cycle after its item is accepted;
//   a degree move first registers its product, then does the reciprocal multiply by 1/45.
// Throughput: one tick, step or revolution item per cycle while the output drains; a
//   degree move holds the input until its step count is set; a register write holds it
//   while the divider loads and runs (a quotient bit per cycle); zero rpm or steps skips it.
// Reset: synchronous, active low; state clears, interval preloads its reset value.
module stepper_phase_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [stps_pkg::IN_TDATA_W-1:0]   in_tdata,  // clockwise, amount, zero pad
  input  logic [stps_pkg::KIND_W-1:0]       in_tuser,  // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [stps_pkg::OUT_TDATA_W-1:0]  out_tdata, // coils, stepped, busy_res, zero pad
  input  logic                              cfg_we,
  input  logic [stps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [stps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  stps_pkg::cfg_t  cfg;
  stps_pkg::item_t item;
  stps_pkg::res_t  res;
  logic            item_acc;
  logic            res_valid;
  logic            deg_pend;
  logic            out_free;
  logic            out_valid_r, out_valid_nxt;
  logic [stps_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign item.kind      = in_tuser;
  assign item.clockwise = in_tdata[0];
  assign item.amount    = in_tdata[stps_pkg::AMOUNT_W:1];

  // Accept while the interval is settled, no degree move is pending and the output slot drains
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !cfg.busy && !deg_pend && out_free;
  assign item_acc  = in_tvalid && in_tready;

  stps_interval_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  stps_seq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_acc  (item_acc),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .deg_pend  (deg_pend)
  );

  // Load the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{stps_pkg::OUT_PAD_W{1'b0}}, res.busy_res, res.stepped, res.coils};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* verif/tb_stepper_phase_sequencer_unit.sv */
`timescale 1ns / 100ps

module tb_stepper_phase_sequencer_unit;
  import stps_pkg::*;

  localparam int unsigned DEG_PER_REV    = 360;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;  // clockwise, amount, zero pad
  logic [KIND_W-1:0] in_tuser = '0;      // kind
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;     // coils, stepped, busy_res, zero pad
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Sequencer model: configuration and motion state
  logic [RPM_W-1:0] rpm_q;
  logic [SPR_W-1:0] spr_q;
  logic half_q;
  logic [TIME_W-1:0] interval_q;
  logic [STEP_W-1:0] steps_left;
  logic dir_ccw;
  logic [PH_W-1:0] phase_q;
  logic [PH_W-1:0] prev_q;
  logic wait_q;
  logic [COIL_COUNT-1:0] coil_q;
  logic [TIME_W-1:0] elapsed_q;

  item_t pending_items[$];
  res_t expected_coils[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  stepper_phase_sequencer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] eff_steps();
    return 64'(spr_q) << half_q;
  endfunction

  // Microseconds between steps; an empty divisor never lets a step through
  function automatic logic [TIME_W-1:0] calc_interval();
    logic [63:0] divisor;
    divisor = eff_steps() * 64'(rpm_q);
    if (divisor == 64'd0) return '1;
    return TIME_W'(64'(US_PER_MIN) / divisor);
  endfunction

  // Apply one accepted item to the model and return the result it should give
  function automatic res_t advance_sequencer(item_t it);
    res_t r;
    r.stepped = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
        if (steps_left != '0 && elapsed_q > interval_q) begin
          elapsed_q = '0;
          wait_q = ~wait_q;
          if (half_q && wait_q) begin
            // release the trailing coil
            coil_q[prev_q] = 1'b0;
          end else begin
            prev_q = phase_q;
            if (dir_ccw) phase_q = PH_W'((prev_q + COIL_COUNT - 1) % COIL_COUNT);
            else phase_q = PH_W'((prev_q + 1) % COIL_COUNT);
            coil_q[phase_q] = 1'b1;
            coil_q[prev_q] = half_q;
          end
          steps_left = steps_left - 1'b1;
          r.stepped = 1'b1;
        end
      end
      KIND_STEPS: steps_left = it.amount;
      KIND_REVS: steps_left = STEP_W'(64'(it.amount[REV_W-1:0]) * eff_steps());
      default: steps_left = STEP_W'((64'(it.amount[DEG_W-1:0]) * eff_steps()) / DEG_PER_REV);
    endcase
    if (it.kind != KIND_TICK) dir_ccw = ~it.clockwise;
    r.coils = coil_q;
    r.busy_res = (steps_left != '0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  // Mostly ticks with moves mixed in; move counts are mostly kept small
  function automatic item_t rand_item();
    item_t it;
    int unsigned sel;
    it.clockwise = 1'($urandom_range(1));
    it.amount = $urandom();
    sel = $urandom_range(99);
    if (sel < 78) begin
      it.kind = KIND_TICK;
    end else if (sel < 88) begin
      it.kind = KIND_STEPS;
      sel = $urandom_range(9);
      if (sel < 7) it.amount = $urandom_range(1, 24);
      else if (sel == 7) it.amount = '0;
    end else if (sel < 94) begin
      it.kind = KIND_REVS;
      if ($urandom_range(3) != 0) it.amount[REV_W-1:0] = REV_W'($urandom_range(2));
    end else begin
      it.kind = KIND_DEGS;
      if ($urandom_range(3) != 0) it.amount[DEG_W-1:0] = DEG_W'($urandom_range(720));
    end
    return it;
  endfunction

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic cw,
                            input logic [AMOUNT_W-1:0] amount);
    item_t it;
    it.kind = kind;
    it.clockwise = cw;
    it.amount = amount;
    pending_items.push_back(it);
  endtask

  // Hold until every queued item has gone in and every result has come out
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_coils.size() != 0)
      @(negedge clk);
  endtask

  // Write one register, then hold until the interval divider releases the input
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RPM: rpm_q = val[RPM_W-1:0];
      REG_STEPS: spr_q = val;
      default: half_q = val[0];
    endcase
    interval_q = calc_interval();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned rpm, input int unsigned spr,
                           input int unsigned half, input int unsigned n_items,
                           input int unsigned s_pct, input int unsigned r_pct,
                           input bit hold, input bit pause);
    write_reg(REG_RPM, CFG_DATA_W'(rpm));
    write_reg(REG_STEPS, CFG_DATA_W'(spr));
    write_reg(REG_HALF, CFG_DATA_W'(half));
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    hold_req = hold;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (pause && i == n_items / 2) wait_drained();
      pending_items.push_back(rand_item());
    end
    wait_drained();
  endtask

  // Driver: offer the next pending item once the current one is taken
  always @(posedge clk) begin
    item_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= IN_TDATA_W'({cur.amount, cur.clockwise});
        in_tuser <= cur.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    item_t seen;
    res_t got;
    res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.kind = in_tuser;
        seen.clockwise = in_tdata[0];
        seen.amount = in_tdata[AMOUNT_W:1];
        expected_coils.push_back(advance_sequencer(seen));
      end
      if (out_tvalid && out_tready) begin
        got.coils = out_tdata[COIL_COUNT-1:0];
        got.stepped = out_tdata[COIL_COUNT];
        got.busy_res = out_tdata[COIL_COUNT+1];
        if (expected_coils.size() == 0) begin
          report_mismatch("unexpected result, coils", 0, got.coils);
        end else begin
          want = expected_coils.pop_front();
          if (got.coils !== want.coils) report_mismatch("coils", want.coils, got.coils);
          if (got.stepped !== want.stepped)
            report_mismatch("stepped", want.stepped, got.stepped);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", want.busy_res, got.busy_res);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rpm_q = RPM_RESET;
    spr_q = SPR_RESET;
    half_q = 1'b0;
    interval_q = calc_interval();
    steps_left = '0;
    dir_ccw = 1'b0;
    phase_q = '0;
    prev_q = '0;
    wait_q = 1'b0;
    coil_q = '0;
    elapsed_q = '0;
    send_idle_pct = 38;
    recv_idle_pct = 48;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: field extremes and out-of-range revolutions and degrees
    queue_item(KIND_TICK, 1'b0, '0);
    queue_item(KIND_STEPS, 1'b1, '0);
    queue_item(KIND_REVS, 1'b0, 32'hFFFF_FF01);
    queue_item(KIND_DEGS, 1'b1, 32'hABCD_0168);
    queue_item(KIND_DEGS, 1'b0, '1);
    queue_item(KIND_REVS, 1'b1, 32'h0000_00FF);
    queue_item(KIND_STEPS, 1'b0, '1);
    queue_item(KIND_TICK, 1'b1, '1);
    wait_drained();

    // Fastest full-step settings: a short move, then a reversal
    write_reg(REG_RPM, CFG_DATA_W'(255));
    write_reg(REG_STEPS, CFG_DATA_W'(65535));
    write_reg(REG_HALF, CFG_DATA_W'(0));
    queue_item(KIND_STEPS, 1'b1, 32'd3);
    repeat (5) queue_item(KIND_TICK, 1'b0, '0);
    queue_item(KIND_DEGS, 1'b0, 32'd1);
    repeat (4) queue_item(KIND_TICK, 1'b1, '1);
    wait_drained();

    // Random phases; mode changes land while steps remain
    run_phase(255, 65535, 1, 300, 38, 48, 1'b0, 1'b0);
    run_phase(200, 40000, 0, 300, 38, 48, 1'b1, 1'b0);
    run_phase(1, 1, 0, 40, 38, 48, 1'b0, 1'b0);
    run_phase(255, 1, 1, 40, 48, 38, 1'b0, 1'b0);
    run_phase(128, 65535, 1, 400, 48, 38, 1'b0, 1'b1);
    run_phase($urandom_range(150, 255), $urandom_range(20000, 65535), $urandom_range(1),
              300, 48, 38, 1'b0, 1'b0);
    run_phase(255, 65535, 0, 300, 0, 0, 1'b0, 1'b0);
    run_phase($urandom_range(150, 255), $urandom_range(20000, 65535), $urandom_range(1),
              300, 0, 0, 1'b0, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_coils.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
